// ----- hdl/running_lcm_accumulator_defines.svh -----
// Assertion macros used by the running LCM accumulator port checker (rla_checker).
`ifndef RUNNING_LCM_ACCUMULATOR_DEFINES_SVH
`define RUNNING_LCM_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rla check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rla check failed");

`endif

// ----- hdl/rla_pkg.sv -----
// Shared constants and controller/datapath interface types for the LCM accumulator.
`timescale 1ns / 1ps
package rla_pkg;

    localparam int DATA_WIDTH = 64;
    localparam int VALUE_W    = 64;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef struct packed {
        logic load;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul_step;
        logic finish;
    } t_rla_cmd;

    typedef struct packed {
        logic fast;
        logic gcd_done;
        logic cnt_zero;
    } t_rla_sts;

endpackage

// ----- hdl/rla_ctrl.sv -----
// Controller state machine for the LCM accumulator: sequences GCD, divide, multiply.
`timescale 1ns / 1ps
module rla_ctrl
    import rla_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    output logic     o_m_tvalid,
    input  logic     i_m_tready,
    input  t_rla_sts i_sts,
    output t_rla_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_GCD,
        ST_DIV,
        ST_MUL,
        ST_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE:   o_cmd.load = i_s_tvalid;
            ST_SETUP:  o_cmd = '0;
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_MUL:    o_cmd.mul_step = 1'b1;
            ST_FINISH: o_cmd.finish = out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    // zero operand or saturated list needs no arithmetic
                    r_state <= i_sts.fast ? ST_FINISH : ST_GCD;
                end
                ST_GCD: begin
                    if (i_sts.gcd_done) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (i_sts.cnt_zero) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (i_sts.cnt_zero) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/rla_dpath.sv -----
// Datapath for the LCM accumulator: binary GCD, restoring divider, shift-add multiplier.
`timescale 1ns / 1ps
module rla_dpath
    import rla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_rla_cmd              i_cmd,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_last,
    output t_rla_sts              o_sts,
    output logic [VALUE_W-1:0]    o_lcm,
    output logic                  o_ovf,
    output logic                  o_last
);

    logic [DATA_WIDTH-1:0] r_acc;
    logic                  r_ovf;
    logic [DATA_WIDTH-1:0] r_v;
    logic                  r_last;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_prod_hi;
    logic [CNT_W-1:0]      r_k;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_out_lcm;
    logic                  r_out_ovf;
    logic                  r_out_last;

    logic                  zero_case;
    logic [DATA_WIDTH-1:0] gcd_val;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   trial_diff;
    logic                  qbit;
    logic [DATA_WIDTH:0]   mul_sum;
    logic                  prod_ovf;
    logic [DATA_WIDTH-1:0] n_res;
    logic                  n_ovf;

    assign zero_case = (r_acc == '0) || (r_v == '0);

    assign o_sts.fast     = zero_case || r_ovf;
    assign o_sts.gcd_done = (r_a == '0) || (r_b == '0);
    assign o_sts.cnt_zero = (r_cnt == '0);

    assign gcd_val    = ((r_a == '0) ? r_b : r_a) << r_k;
    assign trial      = {r_rem, r_a[DATA_WIDTH-1]};
    assign trial_diff = trial - {1'b0, r_b};
    assign qbit       = (trial >= {1'b0, r_b});
    assign mul_sum    = {1'b0, r_prod_hi} + (r_a[0] ? {1'b0, r_v} : '0);
    assign prod_ovf   = (r_prod_hi != '0);

    always_comb begin
        n_ovf = r_ovf;
        if (zero_case) begin
            n_res = '0;
        end else if (r_ovf) begin
            n_res = '1;
        end else if (prod_ovf) begin
            n_res = '1;
            n_ovf = 1'b1;
        end else begin
            n_res = r_a;
        end
    end

    // running state: reset to one / clear, and again after the last item of a list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= DATA_WIDTH'(1);
            r_ovf <= 1'b0;
        end else if (i_cmd.finish) begin
            if (r_last) begin
                r_acc <= DATA_WIDTH'(1);
                r_ovf <= 1'b0;
            end else begin
                r_acc <= n_res;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v    <= i_value[DATA_WIDTH-1:0];
            r_last <= i_last;
            r_a    <= r_acc;
            r_b    <= i_value[DATA_WIDTH-1:0];
            r_k    <= '0;
        end else if (i_cmd.gcd_step) begin
            if (!r_a[0] && !r_b[0]) begin
                r_a <= r_a >> 1;
                r_b <= r_b >> 1;
                r_k <= r_k + CNT_W'(1);
            end else if (!r_a[0]) begin
                r_a <= r_a >> 1;
            end else if (!r_b[0]) begin
                r_b <= r_b >> 1;
            end else if (r_a >= r_b) begin
                r_a <= r_a - r_b;
            end else begin
                r_b <= r_b - r_a;
            end
        end else if (i_cmd.div_init) begin
            // divisor is the gcd, dividend the running multiple
            r_b       <= gcd_val;
            r_a       <= r_acc;
            r_rem     <= '0;
            r_prod_hi <= '0;
            r_cnt     <= CNT_W'(DATA_WIDTH - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? trial_diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
            r_a   <= {r_a[DATA_WIDTH-2:0], qbit};
            r_cnt <= (r_cnt == '0) ? CNT_W'(DATA_WIDTH - 1) : r_cnt - CNT_W'(1);
        end else if (i_cmd.mul_step) begin
            // low product bits shift into the multiplier register
            r_prod_hi <= mul_sum[DATA_WIDTH:1];
            r_a       <= {mul_sum[0], r_a[DATA_WIDTH-1:1]};
            r_cnt     <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_lcm  <= n_res;
            r_out_ovf  <= n_ovf;
            r_out_last <= r_last;
        end
    end

    assign o_lcm  = VALUE_W'(r_out_lcm);
    assign o_ovf  = r_out_ovf;
    assign o_last = r_out_last;

endmodule

// ----- hdl/running_lcm_accumulator.sv -----
// Top level of the running least-common-multiple accumulator.
//
//  channel | direction | tdata             | tlast     | tuser
//  s       | in        | value[63:0]       | last      | -
//  m       | out       | lcm_out[63:0]     | final_res | overflow
//
// Per item: accept, setup, binary GCD loop (one shift or subtract per cycle),
// divider load once the GCD is done, restoring divide steps, shift-add multiply
// steps, one result write. A zero operand or an already saturated list skips the
// arithmetic and goes from setup straight to the result write.
// The result register frees the controller; a stalled m side holds the next
// item in the finish state. Synchronous active-low reset sets the running value to 1.
`timescale 1ns / 1ps
module running_lcm_accumulator
    import rla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,   // [63:0] value
    input  logic               i_s_tlast,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [VALUE_W-1:0] o_m_tdata,   // [63:0] lcm_out
    output logic               o_m_tuser,   // [0] overflow
    output logic               o_m_tlast
);

    t_rla_cmd cmd;
    t_rla_sts sts;

    rla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rla_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_sts   (sts),
        .o_lcm   (o_m_tdata),
        .o_ovf   (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

// ----- hdl/rla_checker.sv -----
// Port-level checks for the LCM accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "running_lcm_accumulator_defines.svh"
module rla_checker
    import rla_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_tvalid,
    input logic               o_s_tready,
    input logic               o_m_tvalid,
    input logic               i_m_tready,
    input logic [VALUE_W-1:0] o_m_tdata,
    input logic               o_m_tuser,
    input logic               o_m_tlast
);

    logic out_stall;
    logic sat_or_zero;

    assign out_stall   = o_m_tvalid && !i_m_tready;
    assign sat_or_zero = (o_m_tdata == VALUE_W'({DATA_WIDTH{1'b1}})) || (o_m_tdata == '0);

    // a stalled result holds its transfer contents
    `RLA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
    // once a list overflowed, every result is saturated or zero
    `RLA_ASSERT_IMP(a_ovf_value, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, sat_or_zero)
    // one item in work at a time
    `RLA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind running_lcm_accumulator rla_checker u_rla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- tb/lcm_checker.sv -----
// Checker for the running LCM accumulator: watches both streams, predicts results and compares.
`timescale 1ns / 1ps
module lcm_checker
    import rla_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [VALUE_W-1:0] i_s_tdata,   // [63:0] value
    input  logic               i_s_tlast,   // last
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [VALUE_W-1:0] i_m_tdata,   // [63:0] lcm_out
    input  logic               i_m_tuser,   // [0] overflow
    input  logic               i_m_tlast,   // final_res
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [VALUE_W-1:0] lcm;
        logic               ovf;
        logic               fin;
    } t_lcm_result;

    localparam logic [VALUE_W-1:0] WIDTH_MASK = ~{VALUE_W{1'b0}} >> (VALUE_W - DATA_WIDTH);
    localparam int                 EXP_DEPTH  = 4;

    logic [VALUE_W-1:0] run_lcm;
    logic               sat_seen;
    t_lcm_result        exp_fifo[EXP_DEPTH];
    int                 exp_wr;
    int                 exp_rd;
    int                 exp_count;
    int                 fail_count;

    function automatic logic [VALUE_W-1:0] euclid_gcd(input logic [VALUE_W-1:0] a,
                                                     input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] r;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // Advance the running multiple by one list element and return the expected transfer.
    function automatic t_lcm_result lcm_predict(input logic [VALUE_W-1:0] value,
                                                input logic last);
        t_lcm_result        res;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] q;
        logic [VALUE_W-1:0] nxt;
        v   = value & WIDTH_MASK;
        acc = run_lcm & WIDTH_MASK;
        if (acc == '0 || v == '0) begin
            nxt = '0;
        end else if (sat_seen) begin
            nxt = WIDTH_MASK;
        end else begin
            q = acc / euclid_gcd(acc, v);
            if (q > WIDTH_MASK / v) begin
                nxt      = WIDTH_MASK;
                sat_seen = 1'b1;
            end else begin
                nxt = q * v;
            end
        end
        run_lcm = nxt;
        res.lcm = nxt & WIDTH_MASK;
        res.ovf = sat_seen;
        res.fin = last;
        if (last) begin
            run_lcm  = VALUE_W'(1);
            sat_seen = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lcm_result exp_res;
        if (!i_rst_n) begin
            run_lcm   = VALUE_W'(1);
            sat_seen  = 1'b0;
            exp_wr    = 0;
            exp_rd    = 0;
            exp_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (exp_count == EXP_DEPTH) begin
                    $error("too many input transfers in flight: %0d", exp_count);
                    fail_count++;
                end else begin
                    exp_fifo[exp_wr] = lcm_predict(i_s_tdata, i_s_tlast);
                    exp_wr           = (exp_wr + 1) % EXP_DEPTH;
                    exp_count++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (exp_count == 0) begin
                    $error("unexpected result transfer: lcm_out %h overflow %b final_res %b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    fail_count++;
                end else begin
                    exp_res = exp_fifo[exp_rd];
                    exp_rd  = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (i_m_tdata !== exp_res.lcm) begin
                        $error("lcm_out mismatch: expected %h actual %h", exp_res.lcm, i_m_tdata);
                        fail_count++;
                    end
                    if (i_m_tuser !== exp_res.ovf) begin
                        $error("overflow mismatch: expected %b actual %b", exp_res.ovf, i_m_tuser);
                        fail_count++;
                    end
                    if (i_m_tlast !== exp_res.fin) begin
                        $error("final_res mismatch: expected %b actual %b",
                               exp_res.fin, i_m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    = exp_count;
        o_fail_count = fail_count;
    end

    initial begin
        fail_count   = 0;
        o_fail_count = 0;
        o_pending    = 0;
        exp_wr       = 0;
        exp_rd       = 0;
        exp_count    = 0;
        run_lcm      = VALUE_W'(1);
        sat_seen     = 1'b0;
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the running LCM accumulator: clock, reset, list stimulus and verdict.
`timescale 1ns / 1ps
module tb_top
    import rla_pkg::*;
();

    localparam int RANDOM_ITEMS = 1400;
    localparam int TAIL_CYCLES  = 300;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;     // [63:0] value
    logic               s_tlast  = 1'b0;   // last
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [VALUE_W-1:0] m_tdata;           // [63:0] lcm_out
    logic               m_tuser;           // [0] overflow
    logic               m_tlast;           // final_res

    int fail_count;
    int pending;
    int items_sent = 0;
    int lists_sent = 0;
    bit calm_phase = 1'b0;

    always #6 clk = ~clk;

    running_lcm_accumulator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    lcm_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Drop the result-side ready at random with a 37 percent chance, except during the calm stretch.
    always @(posedge clk) begin
        m_tready <= calm_phase || ($urandom_range(0, 99) >= 37);
    end

    task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
        int gap;
        gap = 0;
        while (!calm_phase && $urandom_range(0, 99) < 37)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        if (last)
            lists_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] small_composite();
        logic [VALUE_W-1:0] v;
        int n;
        v = VALUE_W'(1);
        n = $urandom_range(1, 3);
        repeat (n) v = v * VALUE_W'($urandom_range(1, 40));
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value(input int style);
        int r;
        r = $urandom_range(0, 99);
        if (style < 55) begin
            // mostly lists that stay in range
            if (r < 4)
                return '0;
            return small_composite();
        end else if (style < 75) begin
            if (r < 30)
                return {$urandom, $urandom};
            if (r < 50)
                return {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(0, VALUE_W - 1);
            if (r < 60)
                return '0;
            return small_composite();
        end else if (style < 90) begin
            if (r < 50)
                return {$urandom, $urandom};
            return {32'd0, $urandom} | 64'd1;
        end else begin
            if (r < 50)
                return ~{VALUE_W{1'b0}} - VALUE_W'($urandom_range(0, 255));
            return ~{VALUE_W{1'b0}} >> $urandom_range(0, VALUE_W - 1);
        end
    endfunction

    task automatic send_random_list();
        int len;
        int style;
        len   = $urandom_range(1, 8);
        style = $urandom_range(0, 99);
        for (int k = 0; k < len; k++)
            send_item(pick_value(style), k == len - 1);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-element lists at the extremes, then a two-element all-ones list
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_item(64'd0, 1'b1);
        send_item(64'd1, 1'b1);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        // zero element holds the running value at zero
        send_item(64'd12, 1'b0);
        send_item(64'd18, 1'b0);
        send_item(64'd0, 1'b0);
        send_item(64'd5, 1'b1);
        // saturate, stay saturated, then zero keeps the sticky flag
        send_item(64'h8000_0000_0000_0000, 1'b0);
        send_item(64'd3, 1'b0);
        send_item(64'd5, 1'b0);
        send_item(64'd0, 1'b0);
        send_item(64'd7, 1'b1);
        // the next list starts clean
        send_item(64'd6, 1'b1);
        // product lands exactly on all ones
        send_item(64'h0000_0000_FFFF_FFFF, 1'b0);
        send_item(64'h0000_0001_0000_0001, 1'b1);
        // repeated and nested powers of two
        send_item(64'h0000_0001_0000_0000, 1'b0);
        send_item(64'h0000_0001_0000_0000, 1'b0);
        send_item(64'h0000_0002_0000_0000, 1'b1);

        while (items_sent < 20 + RANDOM_ITEMS) begin
            calm_phase = (items_sent >= 600 && items_sent < 850);
            send_random_list();
        end
        calm_phase = 1'b0;
        s_tvalid <= 1'b0;

        // let the checker see the last input transfer before draining
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Drove %0d items over %0d lists: corner lists first, then random lists of",
                 items_sent, lists_sent);
        $display("small composites, zeros, powers of two, near-max and full-width values.");
        if (fail_count == 0 && pending == 0)
            $display("running_lcm_accumulator verification clean");
        else
            $display("running_lcm_accumulator verification failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("running_lcm_accumulator verification failed");
        $finish;
    end

endmodule
